FILE: rtl/assert_macros.svh
// Assertion helper macros shared by the detector RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/glcd_pkg.sv
// Shared types, widths, register indexes and side codes for the gate crossing detector.
// No dependencies; every other file but assert_macros.svh imports this package.
package glcd_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIFF_W     = COORD_BITS + 1;   // coordinate difference
    localparam int SQ_W       = 2 * DIFF_W;       // product of two differences
    localparam int SUM_W      = SQ_W + 1;         // sum of two products
    localparam int LIM_W      = 16;
    localparam int TICK_W     = 24;
    localparam int SIDE_W     = 2;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = IDX_W + 2;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // register map, byte address = 4 * index
    localparam logic [IDX_W-1:0] REG_GATE_A_X      = 3'd0;
    localparam logic [IDX_W-1:0] REG_GATE_A_Y      = 3'd1;
    localparam logic [IDX_W-1:0] REG_GATE_B_X      = 3'd2;
    localparam logic [IDX_W-1:0] REG_GATE_B_Y      = 3'd3;
    localparam logic [IDX_W-1:0] REG_JUMP_LIMIT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_NEAR_RADIUS   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DELAY_TICKS   = 3'd6;

    localparam logic [LIM_W-1:0]  JUMP_LIMIT_RST  = 16'd1280;
    localparam logic [LIM_W-1:0]  NEAR_RADIUS_RST = 16'd1280;
    localparam logic [TICK_W-1:0] DELAY_TICKS_RST = 24'd1750;

    // side codes
    localparam logic [SIDE_W-1:0] SIDE_UNKNOWN = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_NEG     = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_ON      = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_POS     = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic [LIM_W-1:0]             jump_limit;
        logic [LIM_W-1:0]             near_radius;
        logic [TICK_W-1:0]            delay_ticks;
    } cfg_t;

    // products handed from the multiply stage to the decision stage
    typedef struct packed {
        logic                   tick;
        logic [SQ_W-1:0]        step_x2;
        logic [SQ_W-1:0]        step_y2;
        logic [SQ_W-1:0]        a_x2;
        logic [SQ_W-1:0]        a_y2;
        logic [SQ_W-1:0]        b_x2;
        logic [SQ_W-1:0]        b_y2;
        logic signed [SQ_W-1:0] cross_p;
        logic signed [SQ_W-1:0] cross_q;
        logic [2*LIM_W-1:0]     lim2;
        logic [2*LIM_W-1:0]     rad2;
    } prod_t;

    typedef struct packed {
        logic              reset_pulse;
        logic              crossed;
        logic              jump_seen;
        logic [SIDE_W-1:0] side;
    } res_t;

    function automatic logic signed [DIFF_W-1:0] diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] ae;
        logic signed [DIFF_W-1:0] be;
        ae = {a[COORD_BITS-1], a};
        be = {b[COORD_BITS-1], b};
        return ae - be;
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] r;
        r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return r;
    endfunction

endpackage

FILE: rtl/glcd_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on glcd_pkg.
interface glcd_in_if import glcd_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;

    modport source (output valid, req_type, pos_x, pos_y, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, output ready);
endinterface

interface glcd_out_if import glcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              reset_pulse;
    logic              crossed;
    logic              jump_seen;
    logic [SIDE_W-1:0] side;

    modport source (output valid, reset_pulse, crossed, jump_seen, side, input ready);
    modport sink   (input valid, reset_pulse, crossed, jump_seen, side, output ready);
endinterface

FILE: rtl/glcd_regs.sv
// APB-style configuration registers of the gate crossing detector.
// Depends on glcd_pkg.
module glcd_regs import glcd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a_x         <= '0;
            cfg_reg.a_y         <= '0;
            cfg_reg.b_x         <= '0;
            cfg_reg.b_y         <= '0;
            cfg_reg.jump_limit  <= JUMP_LIMIT_RST;
            cfg_reg.near_radius <= NEAR_RADIUS_RST;
            cfg_reg.delay_ticks <= DELAY_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GATE_A_X:    cfg_reg.a_x         <= COORD_BITS'(pwdata);
                REG_GATE_A_Y:    cfg_reg.a_y         <= COORD_BITS'(pwdata);
                REG_GATE_B_X:    cfg_reg.b_x         <= COORD_BITS'(pwdata);
                REG_GATE_B_Y:    cfg_reg.b_y         <= COORD_BITS'(pwdata);
                REG_JUMP_LIMIT:  cfg_reg.jump_limit  <= pwdata[LIM_W-1:0];
                REG_NEAR_RADIUS: cfg_reg.near_radius <= pwdata[LIM_W-1:0];
                REG_DELAY_TICKS: cfg_reg.delay_ticks <= pwdata[TICK_W-1:0];
                default: ;   // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GATE_A_X:    prdata = DATA_W'(cfg_reg.a_x);
            REG_GATE_A_Y:    prdata = DATA_W'(cfg_reg.a_y);
            REG_GATE_B_X:    prdata = DATA_W'(cfg_reg.b_x);
            REG_GATE_B_Y:    prdata = DATA_W'(cfg_reg.b_y);
            REG_JUMP_LIMIT:  prdata = DATA_W'(cfg_reg.jump_limit);
            REG_NEAR_RADIUS: prdata = DATA_W'(cfg_reg.near_radius);
            REG_DELAY_TICKS: prdata = DATA_W'(cfg_reg.delay_ticks);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/glcd_mult.sv
// Multiply stage: differences, squares and cross-product terms, registered.
// Depends on glcd_pkg.
module glcd_mult import glcd_pkg::*; (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         tick,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] lx,
    input  logic signed [COORD_BITS-1:0] ly,
    input  cfg_t                         cfg,
    output prod_t                        prod
);

    prod_t                    prod_reg;
    prod_t                    prod_next;
    logic [DIFF_W-1:0]        m_sx, m_sy, m_ax, m_ay, m_bx, m_by;
    logic signed [DIFF_W-1:0] u1, v1, u2, v2;

    always_comb
    begin
        m_sx = mag(diff(px, lx));
        m_sy = mag(diff(py, ly));
        m_ax = mag(diff(px, cfg.a_x));
        m_ay = mag(diff(py, cfg.a_y));
        m_bx = mag(diff(px, cfg.b_x));
        m_by = mag(diff(py, cfg.b_y));
        // side of line: sign of (B-A)x * (P-A)y - (B-A)y * (P-A)x
        u1 = diff(cfg.b_x, cfg.a_x);
        v1 = diff(py, cfg.a_y);
        u2 = diff(cfg.b_y, cfg.a_y);
        v2 = diff(px, cfg.a_x);

        prod_next.tick    = tick;
        prod_next.step_x2 = SQ_W'(m_sx) * SQ_W'(m_sx);
        prod_next.step_y2 = SQ_W'(m_sy) * SQ_W'(m_sy);
        prod_next.a_x2    = SQ_W'(m_ax) * SQ_W'(m_ax);
        prod_next.a_y2    = SQ_W'(m_ay) * SQ_W'(m_ay);
        prod_next.b_x2    = SQ_W'(m_bx) * SQ_W'(m_bx);
        prod_next.b_y2    = SQ_W'(m_by) * SQ_W'(m_by);
        prod_next.cross_p = SQ_W'(u1) * SQ_W'(v1);
        prod_next.cross_q = SQ_W'(u2) * SQ_W'(v2);
        prod_next.lim2    = (2*LIM_W)'(cfg.jump_limit) * (2*LIM_W)'(cfg.jump_limit);
        prod_next.rad2    = (2*LIM_W)'(cfg.near_radius) * (2*LIM_W)'(cfg.near_radius);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/glcd_decide.sv
// Decision stage: jump, side, crossing and delay counter; holds the track state.
// Depends on glcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module glcd_decide import glcd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  prod_t             prod,
    input  logic [TICK_W-1:0] delay_ticks,
    output res_t              res
);

    logic [SIDE_W-1:0] last_side_reg, last_side_next;
    logic              running_reg, running_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    res_t              res_reg, res_next;

    logic [SUM_W-1:0]        d2_step, d2_a, d2_b;
    logic signed [SUM_W-1:0] cross_d;
    logic [SIDE_W-1:0]       prev_side, side_now;
    logic                    jump, near, crossing;

    always_comb
    begin
        d2_step = SUM_W'(prod.step_x2) + SUM_W'(prod.step_y2);
        d2_a    = SUM_W'(prod.a_x2) + SUM_W'(prod.a_y2);
        d2_b    = SUM_W'(prod.b_x2) + SUM_W'(prod.b_y2);
        cross_d = SUM_W'(prod.cross_p) - SUM_W'(prod.cross_q);

        jump      = d2_step > SUM_W'(prod.lim2);
        near      = (d2_a < SUM_W'(prod.rad2)) || (d2_b < SUM_W'(prod.rad2));
        prev_side = jump ? SIDE_UNKNOWN : last_side_reg;

        if (cross_d[SUM_W-1])
            side_now = SIDE_NEG;
        else if (cross_d == '0)
            side_now = SIDE_ON;
        else
            side_now = SIDE_POS;

        crossing = (prev_side != SIDE_UNKNOWN) && near && (side_now != prev_side);

        last_side_next = last_side_reg;
        running_next   = running_reg;
        elapsed_next   = elapsed_reg;
        res_next       = '0;

        if (prod.tick)
        begin
            if (elapsed_reg != TICK_MAX)
                elapsed_next = elapsed_reg + 1'b1;
            res_next.side = last_side_reg;
        end
        else
        begin
            last_side_next     = side_now;
            res_next.side      = side_now;
            res_next.jump_seen = jump;
            res_next.crossed   = crossing;
            if (crossing)
            begin
                elapsed_next = '0;
                running_next = 1'b1;
            end
            else if (running_reg && (elapsed_reg >= delay_ticks))
            begin
                res_next.reset_pulse = 1'b1;
                running_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_side_reg <= SIDE_UNKNOWN;
            running_reg   <= 1'b0;
            elapsed_reg   <= '0;
        end
        else if (load)
        begin
            last_side_reg <= last_side_next;
            running_reg   <= running_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    `ASSERT_NEVER(a_jump_no_cross, load && res_next.crossed && res_next.jump_seen,
                  "crossing reported on a jump sample")
    `ASSERT_CLK(a_pulse_needs_delay, load && res_next.reset_pulse |-> running_reg,
                "reset pulse without a running delay")
    `ASSERT_CLK(a_cross_restarts, load && res_next.crossed |=> running_reg && elapsed_reg == '0,
                "crossing did not restart the delay counter")

endmodule

FILE: rtl/gate_line_crossing_detector.sv
// Gate line crossing detector, top level: APB registers, three-stage word pipeline.
// Depends on glcd_pkg, glcd_if, glcd_regs, glcd_mult, glcd_decide.
//
// Usage:
//   sample : valid/ready input channel; each word is a position sample
//            (req_type 0, pos_x/pos_y in 1/256 m) or a time tick (req_type 1).
//   result : valid/ready output channel; exactly one word per input word,
//            in order: reset_pulse, crossed, jump_seen, side.
//   APB    : gate endpoints, jump_limit, near_radius, delay_ticks at 4*index.
//            Write only while the pipeline is empty.
// Path: a word passes the input register, the multiply register and the result register,
//   in that order; its result is valid while it sits in the result register.
// Throughput: one word per cycle while result.ready is high; the track state (last side,
//   delay counter) updates within the decision stage, so words follow back to back.
// Reset: pipeline empties, last position goes to the origin, side unknown,
//   delay counter idle; registers take their documented reset values.
// Stall: when result.ready is low the full pipeline holds; sample.ready drops
//   only once all three stages hold a word.
module gate_line_crossing_detector import glcd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    glcd_in_if.sink           sample,
    glcd_out_if.source        result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    // pipeline occupancy
    logic v0_reg, v1_reg, v2_reg;
    logic adv0, adv1, adv2;
    logic in_acc;

    // input register: the word plus the previous sample position
    logic                         tick_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, lx_reg, ly_reg;
    // last accepted sample position (reset to the origin)
    logic signed [COORD_BITS-1:0] last_x_reg, last_y_reg;

    prod_t prod;
    res_t  res;

    glcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage moves on when it is empty or the stage after it moves
    assign adv2   = !v2_reg || result.ready;
    assign adv1   = !v1_reg || adv2;
    assign adv0   = !v0_reg || adv1;
    assign in_acc = sample.valid && adv0;

    assign sample.ready = adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else
        begin
            if (adv0)
                v0_reg <= sample.valid;
            if (adv1)
                v1_reg <= v0_reg;
            if (adv2)
                v2_reg <= v1_reg;
            // ticks leave the remembered position alone
            if (in_acc && !sample.req_type)
            begin
                last_x_reg <= sample.pos_x;
                last_y_reg <= sample.pos_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tick_reg <= sample.req_type;
            px_reg   <= sample.pos_x;
            py_reg   <= sample.pos_y;
            lx_reg   <= last_x_reg;
            ly_reg   <= last_y_reg;
        end
    end

    glcd_mult u_mult (
        .clk  (clk),
        .load (adv1 && v0_reg),
        .tick (tick_reg),
        .px   (px_reg),
        .py   (py_reg),
        .lx   (lx_reg),
        .ly   (ly_reg),
        .cfg  (cfg),
        .prod (prod)
    );

    glcd_decide u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (adv2 && v1_reg),
        .prod        (prod),
        .delay_ticks (cfg.delay_ticks),
        .res         (res)
    );

    assign result.valid       = v2_reg;
    assign result.reset_pulse = res.reset_pulse;
    assign result.crossed     = res.crossed;
    assign result.jump_seen   = res.jump_seen;
    assign result.side        = res.side;

endmodule
